// File: rtl/core/shadow_stack_checker_defines.svh
// ----------------------------------------------------------------------------
// Shadow stack checker assertion macros
// Short forms for the concurrent checks of the shadow stack checker.
// ----------------------------------------------------------------------------
`ifndef SHADOW_STACK_CHECKER_DEFINES_SVH
`define SHADOW_STACK_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SHSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SHSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/shsc_pkg.sv
// ----------------------------------------------------------------------------
// Shadow stack checker package
// Word types, defaults and command codes shared by the checker modules.
// ----------------------------------------------------------------------------
package shsc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int ADDR_BITS_DEF   = 64;

  // Event kinds on the command port.
  localparam logic OP_CALL   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  // Classified command kinds handed from the front end to the back end.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVF   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UDF   = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [63:0] return_address;
    logic [63:0] frame_pointer;
  } cmd_word_t;

  typedef struct packed {
    logic        return_mismatch;
    logic        frame_mismatch;
    logic [63:0] expected_return;
    logic [63:0] expected_frame;
    logic        underflow;
    logic        overflow;
  } result_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: rtl/core/shsc_front.sv
// ----------------------------------------------------------------------------
// Shadow stack checker front end
// Accepts events, tracks the stack level and classifies each event.
// ----------------------------------------------------------------------------
module shsc_front #(
  parameter int STACK_DEPTH = shsc_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = shsc_pkg::ADDR_BITS_DEF,
  parameter int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int ENTRY_W     = shsc_pkg::KIND_W + IDX_W + 2 * ADDR_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  shsc_pkg::cmd_word_t cmd,
  input  logic                q_full,
  output logic                busy,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_data
);
  import shsc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0]     level;
  logic [CNT_W-1:0]     level_next;
  logic [CNT_W-1:0]     level_dec;
  logic [KIND_W-1:0]    kind;
  logic [IDX_W-1:0]     idx;
  logic                 is_full;
  logic                 is_empty;

  assign busy      = q_full;
  assign q_push    = start && !q_full;
  assign is_full   = (level == CNT_W'(STACK_DEPTH));
  assign is_empty  = (level == '0);
  assign level_dec = level - CNT_W'(1);

  always_comb begin
    kind       = KIND_PUSH;
    idx        = level[IDX_W-1:0];
    level_next = level;
    if (cmd.opcode == OP_CALL) begin
      if (is_full) begin
        kind = KIND_OVF;
      end else begin
        kind       = KIND_PUSH;
        level_next = level + CNT_W'(1);
      end
    end else begin
      idx = level_dec[IDX_W-1:0];
      if (is_empty) begin
        kind = KIND_UDF;
      end else begin
        kind       = KIND_CHECK;
        level_next = level_dec;
      end
    end
  end

  assign q_data = {kind, idx, cmd.return_address[ADDR_BITS-1:0],
                   cmd.frame_pointer[ADDR_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (q_push) begin
      level <= level_next;
    end
  end

endmodule

// File: rtl/core/shsc_queue.sv
// ----------------------------------------------------------------------------
// Shadow stack checker command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module shsc_queue #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output shsc_pkg::queue_stat_t  stat
);
  import shsc_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/shsc_back.sv
// ----------------------------------------------------------------------------
// Shadow stack checker back end
// Holds the paired shadow stacks, performs pushes and checked returns.
// ----------------------------------------------------------------------------
module shsc_back #(
  parameter int STACK_DEPTH = shsc_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = shsc_pkg::ADDR_BITS_DEF,
  parameter int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int ENTRY_W     = shsc_pkg::KIND_W + IDX_W + 2 * ADDR_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ENTRY_W-1:0]     q_data,
  input  shsc_pkg::queue_stat_t  q_stat,
  output logic                   q_pop,
  output logic                   done,
  output shsc_pkg::result_word_t result
);
  import shsc_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CHECK = 1'b1;

  logic [ADDR_BITS-1:0] ret_mem [STACK_DEPTH];
  logic [ADDR_BITS-1:0] frm_mem [STACK_DEPTH];

  logic                 state;
  logic [KIND_W-1:0]    kind;
  logic [IDX_W-1:0]     idx;
  logic [ADDR_BITS-1:0] ra_in;
  logic [ADDR_BITS-1:0] fp_in;
  logic [ADDR_BITS-1:0] ra_rd;
  logic [ADDR_BITS-1:0] fp_rd;
  logic [ADDR_BITS-1:0] ra_hold;
  logic [ADDR_BITS-1:0] fp_hold;
  logic                 wr_en;
  logic                 rd_en;
  result_word_t         result_next;

  assign kind  = q_data[ENTRY_W-1 -: KIND_W];
  assign idx   = q_data[2*ADDR_BITS +: IDX_W];
  assign ra_in = q_data[ADDR_BITS +: ADDR_BITS];
  assign fp_in = q_data[0 +: ADDR_BITS];

  assign q_pop = (state == ST_IDLE) && !q_stat.empty;
  assign wr_en = q_pop && (kind == KIND_PUSH);
  assign rd_en = q_pop && (kind == KIND_CHECK);

  // Stack storage: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ret_mem[idx] <= ra_in;
      frm_mem[idx] <= fp_in;
    end
    if (rd_en) begin
      ra_rd   <= ret_mem[idx];
      fp_rd   <= frm_mem[idx];
      ra_hold <= ra_in;
      fp_hold <= fp_in;
    end
  end

  always_comb begin
    result_next = '0;
    if (state == ST_CHECK) begin
      result_next.return_mismatch = (ra_rd != ra_hold);
      result_next.frame_mismatch  = (fp_rd != fp_hold);
      result_next.expected_return = 64'(ra_rd);
      result_next.expected_frame  = 64'(fp_rd);
    end else begin
      result_next.overflow  = (kind == KIND_OVF);
      result_next.underflow = (kind == KIND_UDF);
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (kind == KIND_CHECK) begin
              state <= ST_CHECK;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/shadow_stack_checker.sv
// ----------------------------------------------------------------------------
// Shadow stack checker
// Paired hardware shadow stacks of return addresses and frame pointers.
// ----------------------------------------------------------------------------
// Each call or return event is a word on cmd, taken when start is high and
// busy is low; every event yields exactly one result word on result, shown
// for one cycle while done is high, and the receiver cannot hold it off. A
// call pushes the return address and frame pointer and reports zeros, or
// sets overflow and drops the push when the stack already holds STACK_DEPTH
// entries. A return compares against the top entries, reports the stored
// values with a mismatch flag for each, and pops; on an empty stack it sets
// underflow and changes nothing. Addresses are kept in their low ADDR_BITS
// bits. The result word of a call is registered by the back end as it pops
// the call from the queue; a return first passes through the registered
// read of the stack memories and the check state. The back end retires one
// call per cycle while no return is in its check state; a return holds it
// there until the stored values are compared. A two-entry queue sits between
// the event decoder and the stack engine, so busy rises only once that queue
// is full. The stores need no clearing after reset: an entry is never read
// before it is pushed.
// ----------------------------------------------------------------------------
`include "shadow_stack_checker_defines.svh"

module shadow_stack_checker #(
  parameter int STACK_DEPTH = shsc_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = shsc_pkg::ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  shsc_pkg::cmd_word_t    cmd,
  output logic                   busy,
  output logic                   done,
  output shsc_pkg::result_word_t result
);
  import shsc_pkg::*;

  // Queue entry layout: kind, stack index, return address, frame pointer.
  localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ENTRY_W = KIND_W + IDX_W + 2 * ADDR_BITS;

  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  queue_stat_t        q_stat;

  // The front end owns the stack level, so every event is classified in
  // order as it arrives and the back end never has to look at the level.
  shsc_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .IDX_W       (IDX_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .q_full (q_stat.full),
    .busy   (busy),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  shsc_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // The back end drains the queue, writing pushes into the stack memories
  // and turning each checked return into a read followed by the compare.
  shsc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .IDX_W       (IDX_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_data (q_rdata),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .done   (done),
    .result (result)
  );

  // An event is either an overflowing call or an underflowing return, not both.
  `SHSC_ASSERT_IMP(a_flags_exclusive, done, !(result.underflow && result.overflow), "overflow and underflow together")
  // A flagged event carries no compare results.
  `SHSC_ASSERT_IMP(a_flag_quiet, done && (result.underflow || result.overflow), !result.return_mismatch && !result.frame_mismatch && (result.expected_return == 64'd0) && (result.expected_frame == 64'd0), "flagged event with compare data")
  // The queue cannot be full and empty at once.
  `SHSC_ASSERT_IMP(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  // An accepted event is in the queue on the next cycle.
  `SHSC_ASSERT_NEXT(a_accept_queued, start && !busy, !q_stat.empty, "accepted event lost")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shadow stack checker testbench
// Sends call and return event words to the checker and checks every result
// word against a shadow stack kept inside the testbench.
// ----------------------------------------------------------------------------
// The stimulus opens with a handful of hand-picked events: returns on an
// empty stack, calls with all-zero and all-one fields, and returns that
// match, miss on the frame pointer, miss on the return address or miss on
// both. Next the stack is filled to the brim and pushed past it, then
// unwound to empty. The bulk of the run is a random walk of properly nested
// calls and returns with random contents; its drift changes from segment to
// segment, so the stack keeps hitting both its floor and its ceiling, and a
// share of the returns carry a corrupted return address or frame pointer.
// ----------------------------------------------------------------------------

module testbench;
  import shsc_pkg::*;

  localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int ADDR_BITS    = ADDR_BITS_DEF;
  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

  localparam int RANDOM_ITEMS = 1560;
  // The tail of the random part runs with no gaps at all, so the checker
  // also sees a long stretch of back-to-back events.
  localparam int QUIET_ITEMS  = 250;
  // With an empty queue, the result word of a call or of a return is
  // accepted well within this stretch of quiet, so it is ample to catch
  // stray words.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // Scoreboard: mirrors both shadow stacks and queues the result word that
  // each accepted event must produce, oldest first.
  class shadow_scoreboard;
    logic [63:0]  return_copy [STACK_DEPTH];
    logic [63:0]  frame_copy [STACK_DEPTH];
    int unsigned  depth;
    result_word_t awaited_q[$];
    int unsigned  errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    function void note_event(cmd_word_t c);
      result_word_t r;
      logic [63:0]  ra;
      logic [63:0]  fp;
      r  = '0;
      ra = c.return_address & ADDR_MASK;
      fp = c.frame_pointer & ADDR_MASK;
      if (c.opcode == OP_CALL) begin
        // A call on a full stack is flagged and its push is dropped.
        if (depth >= STACK_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          return_copy[depth] = ra;
          frame_copy[depth]  = fp;
          depth++;
        end
      end else if (depth == 0) begin
        // A return with nothing to compare against only raises underflow.
        r.underflow = 1'b1;
      end else begin
        depth--;
        r.expected_return = return_copy[depth];
        r.expected_frame  = frame_copy[depth];
        r.return_mismatch = (return_copy[depth] != ra);
        r.frame_mismatch  = (frame_copy[depth] != fp);
      end
      awaited_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (awaited_q.size() == 0) begin
        $error("result word arrived with no event outstanding");
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      compare_field("return_mismatch", 64'(want.return_mismatch),
                    64'(got.return_mismatch));
      compare_field("frame_mismatch", 64'(want.frame_mismatch),
                    64'(got.frame_mismatch));
      compare_field("expected_return", want.expected_return, got.expected_return);
      compare_field("expected_frame", want.expected_frame, got.expected_frame);
      compare_field("underflow", 64'(want.underflow), 64'(got.underflow));
      compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic         clk = 1'b1;
  logic         rst;
  logic         start;
  cmd_word_t    cmd;
  logic         busy;
  logic         done;
  result_word_t result;

  shadow_scoreboard sb;
  int unsigned      cycle_count;
  logic             idle_enabled;

  // Generator's view of the stack, used to build returns that match.
  logic [63:0] live_returns[$];
  logic [63:0] live_frames[$];

  shadow_stack_checker uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: a hung checker ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both handshakes are sampled on the same edge. An event is always noted
  // before a result is checked, though the latency keeps them apart anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_event(cmd);
      end
      if (done) begin
        sb.check_result(result);
      end
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly random contents, with the all-zero and all-one extremes mixed in.
  function automatic logic [63:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return '0;
    end
    if (roll < 10) begin
      return '1;
    end
    return random_word();
  endfunction

  // Either a single flipped bit, the subtle case, or a wholly wrong value.
  function automatic logic [63:0] corrupt(logic [63:0] v);
    if ($urandom_range(0, 1) == 0) begin
      return v ^ (64'd1 << $urandom_range(0, 63));
    end
    return ~v ^ random_word() & random_word();
  endfunction

  // Holds start high until the word is taken. An optional gap in front
  // lowers start for a random burst of cycles first.
  task automatic send_word(input cmd_word_t w);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue_call(input logic [63:0] ra, input logic [63:0] fp);
    cmd_word_t w;
    w.opcode         = OP_CALL;
    w.return_address = ra;
    w.frame_pointer  = fp;
    send_word(w);
    if (live_returns.size() < STACK_DEPTH) begin
      live_returns.push_back(ra);
      live_frames.push_back(fp);
    end
  endtask

  task automatic issue_return(input logic [63:0] ra, input logic [63:0] fp);
    cmd_word_t w;
    w.opcode         = OP_RETURN;
    w.return_address = ra;
    w.frame_pointer  = fp;
    send_word(w);
    if (live_returns.size() != 0) begin
      void'(live_returns.pop_back());
      void'(live_frames.pop_back());
    end
  endtask

  // A return built from the generator's top entry; on an empty stack the
  // contents are simply random.
  task automatic issue_random_return();
    logic [63:0] ra;
    logic [63:0] fp;
    int unsigned roll;
    if (live_returns.size() == 0) begin
      issue_return(random_word(), random_word());
    end else begin
      ra   = live_returns[$];
      fp   = live_frames[$];
      roll = $urandom_range(0, 99);
      if (roll >= 82 && roll < 88) begin
        ra = corrupt(ra);
      end else if (roll >= 88 && roll < 94) begin
        fp = corrupt(fp);
      end else if (roll >= 94) begin
        ra = corrupt(ra);
        fp = corrupt(fp);
      end
      issue_return(ra, fp);
    end
  endtask

  task automatic run_directed();
    // Return on an empty stack.
    issue_return(random_word(), random_word());
    issue_call('0, '0);
    issue_call('1, '1);
    issue_call(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    // Exact match, then frame pointer wrong, then return address wrong.
    issue_return(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_return('1, 64'h7FFF_FFFF_FFFF_FFFF);
    issue_return(64'h8000_0000_0000_0000, '0);
    // The stack is empty again.
    issue_return('0, '0);
    // Both fields wrong at once.
    issue_call(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    issue_return(64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF);
    // A call straight after a return and a short nest that unwinds cleanly.
    issue_call(random_word(), random_word());
    issue_call(random_word(), random_word());
    issue_return(live_returns[$], live_frames[$]);
    issue_return(live_returns[$], live_frames[$]);
  endtask

  // Fill to the brim, push past it a few times, then unwind to below empty.
  task automatic run_fill_and_drain();
    while (live_returns.size() < STACK_DEPTH) begin
      issue_call(pick_address(), pick_address());
    end
    repeat (3) issue_call(pick_address(), pick_address());
    while (live_returns.size() != 0) begin
      issue_random_return();
    end
    issue_return(random_word(), random_word());
  endtask

  // Random walk in segments: balanced, climbing toward overflow, or
  // sinking toward underflow.
  task automatic run_random();
    int unsigned segment_left;
    int unsigned call_pct;
    int unsigned roll;
    segment_left = 0;
    call_pct     = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 120);
        roll         = $urandom_range(0, 3);
        call_pct     = (roll == 0) ? 80 : (roll == 1) ? 30 : 50;
      end
      segment_left--;
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_enabled = 1'b0;
      end
      if ($urandom_range(0, 99) < call_pct) begin
        issue_call(pick_address(), pick_address());
      end else begin
        issue_random_return();
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cycle_count  = 0;
    idle_enabled = 1'b1;
    sb           = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_fill_and_drain();
    run_random();
    start <= 1'b0;

    // Every event is in; wait for the last result words, then a little more
    // so that any surplus word is caught by the monitor.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
